[hw/rtl/indexed_list_store_core_macros.svh]
// Assertion macros shared by the indexed list store RTL.
// Needs nothing else; included by the top level only.
`ifndef INDEXED_LIST_STORE_CORE_MACROS_SVH
`define INDEXED_LIST_STORE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ILS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("indexed list store: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ILS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("indexed list store: next-cycle check failed");

`endif

[hw/rtl/ils_pkg.sv]
// Shared types and constants of the indexed list store.
// Used by the channel interfaces, the controller, the datapath and the top level.
package ils_pkg;

   localparam int OP_WIDTH    = 3;
   localparam int INDEX_WIDTH = 8;
   localparam int ELEM_WIDTH  = 32;
   localparam int COUNT_WIDTH = 9;

   typedef logic [OP_WIDTH-1:0]    op_type;
   typedef logic [INDEX_WIDTH-1:0] index_type;
   typedef logic [ELEM_WIDTH-1:0]  elem_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   localparam op_type OP_READ   = 3'd0;
   localparam op_type OP_WRITE  = 3'd1;
   localparam op_type OP_APPEND = 3'd2;
   localparam op_type OP_REMOVE = 3'd3;
   localparam op_type OP_CLEAR  = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SHIFT = 4'b0010,
      ST_RESP  = 4'b0100,
      ST_SPARE = 4'b1000
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;
      logic shift;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic needs_shift;
      logic shift_last;
   } stat_type;

endpackage

[hw/rtl/ils_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on ils_pkg for the payload types.
interface ils_req_if;
   logic               valid;
   logic               ready;
   ils_pkg::op_type    op;
   ils_pkg::index_type index;
   ils_pkg::elem_type  element;

   modport source (output valid, output op, output index, output element, input ready);
   modport sink   (input valid, input op, input index, input element, output ready);
endinterface

interface ils_rsp_if;
   logic              valid;
   logic              ready;
   ils_pkg::elem_type read_data;
   logic              out_of_bounds;
   logic              full_res;
   ils_pkg::count_type count;

   modport source (output valid, output read_data, output out_of_bounds,
                   output full_res, output count, input ready);
   modport sink   (input valid, input read_data, input out_of_bounds,
                   input full_res, input count, output ready);
endinterface

[hw/rtl/ils_datapath.sv]
// Datapath of the indexed list store: element memory, count, shift pointer, result flags.
// Depends on ils_pkg; driven by ils_controller through cmd and stat.
module ils_datapath #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  ils_pkg::cmd_type   cmd,
   output ils_pkg::stat_type  stat,
   input  ils_pkg::op_type    req_op,
   input  ils_pkg::index_type req_index,
   input  ils_pkg::elem_type  req_element,
   output ils_pkg::elem_type  rsp_read_data,
   output logic               rsp_out_of_bounds,
   output logic               rsp_full_res,
   output ils_pkg::count_type rsp_count
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [DATA_WIDTH-1:0] store_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rdata_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic          oob_ff, oob_in;
   logic          full_ff, full_in;
   logic          rd_hit_ff, rd_hit_in;

   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_wa, mem_ra;
   logic [DATA_WIDTH-1:0] mem_wd;
   logic                  in_range;

   assign in_range = 32'(req_index) < 32'(count_ff);

   assign stat.needs_shift = (req_op == ils_pkg::OP_REMOVE) &&
                             ((32'(req_index) + 32'd1) < 32'(count_ff));
   // The count is already decremented while shifting, so the last
   // destination is the new count minus one.
   assign stat.shift_last  = (32'(ptr_ff) + 32'd1) == 32'(count_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wa    = ptr_ff;
      mem_ra    = AW'(32'(ptr_ff) + 32'd2);
      mem_wd    = rdata_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      oob_in    = oob_ff;
      full_in   = full_ff;
      rd_hit_in = rd_hit_ff;
      if (cmd.accept) begin
         oob_in    = 1'b0;
         full_in   = 1'b0;
         rd_hit_in = 1'b0;
         ptr_in    = AW'(req_index);
         case (req_op)
            ils_pkg::OP_READ: begin
               mem_re    = in_range;
               mem_ra    = AW'(req_index);
               rd_hit_in = in_range;
               oob_in    = !in_range;
            end
            ils_pkg::OP_WRITE: begin
               mem_we = in_range;
               mem_wa = AW'(req_index);
               mem_wd = DATA_WIDTH'(req_element);
               oob_in = !in_range;
            end
            ils_pkg::OP_APPEND: begin
               if (count_ff == CW'(CAPACITY)) begin
                  full_in = 1'b1;
               end else begin
                  mem_we   = 1'b1;
                  mem_wa   = AW'(count_ff);
                  mem_wd   = DATA_WIDTH'(req_element);
                  count_in = count_ff + CW'(1);
               end
            end
            ils_pkg::OP_REMOVE: begin
               // Fetch the first word to move down; unused if nothing follows.
               mem_re = in_range;
               mem_ra = AW'(32'(req_index) + 32'd1);
               oob_in = !in_range;
               if (in_range) begin
                  count_in = count_ff - CW'(1);
               end
            end
            ils_pkg::OP_CLEAR: begin
               count_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.shift) begin
         // Write the word fetched last cycle one place down, fetch the next.
         mem_we = 1'b1;
         mem_re = 1'b1;
         ptr_in = ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rdata_ff <= store_ff[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      oob_ff    <= oob_in;
      full_ff   <= full_in;
      rd_hit_ff <= rd_hit_in;
   end

   assign rsp_read_data     = rd_hit_ff ? ils_pkg::ELEM_WIDTH'(rdata_ff) : '0;
   assign rsp_out_of_bounds = oob_ff;
   assign rsp_full_res      = full_ff;
   assign rsp_count         = ils_pkg::COUNT_WIDTH'(count_ff);

endmodule

[hw/rtl/ils_controller.sv]
// Controller of the indexed list store: sequences accept, shift and response.
// Depends on ils_pkg; commands ils_datapath.
module ils_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ils_pkg::cmd_type  cmd,
   input  ils_pkg::stat_type stat
);

   ils_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.accept = 1'b0;
      cmd.shift  = 1'b0;
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      case (state_ff)
         ils_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = stat.needs_shift ? ils_pkg::ST_SHIFT : ils_pkg::ST_RESP;
            end
         end
         ils_pkg::ST_SHIFT: begin
            cmd.shift = 1'b1;
            if (stat.shift_last) begin
               state_in = ils_pkg::ST_RESP;
            end
         end
         ils_pkg::ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ils_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ils_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ils_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[hw/rtl/indexed_list_store_core.sv]
// Indexed list store: read, write, append, remove and clear on a list of words.
// Read, write, append, clear, unknown ops and out-of-range removes: result valid in the cycle after accept.
// In-range remove: the words after the index move down one place, one word moved per cycle, then the result.
// A new request is accepted the cycle after the result is taken, not before.
// Synchronous reset empties the list; stored words are not cleared.
`include "indexed_list_store_core_macros.svh"

module indexed_list_store_core #(
   parameter int CAPACITY   = 256,
   parameter int DATA_WIDTH = 32
) (
   input logic         clock,
   input logic         reset,
   ils_req_if.sink     req_chan,
   ils_rsp_if.source   rsp_chan
);

   ils_pkg::cmd_type  cmd;
   ils_pkg::stat_type stat;

   ils_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   ils_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_op            (req_chan.op),
      .req_index         (req_chan.index),
      .req_element       (req_chan.element),
      .rsp_read_data     (rsp_chan.read_data),
      .rsp_out_of_bounds (rsp_chan.out_of_bounds),
      .rsp_full_res      (rsp_chan.full_res),
      .rsp_count         (rsp_chan.count)
   );

   `ILS_ASSERT_SAME(a_accept_only_idle, clock, reset, cmd.accept, req_chan.valid && !rsp_chan.valid)
   `ILS_ASSERT_SAME(a_no_shift_on_accept, clock, reset, cmd.shift, !req_chan.ready && !rsp_chan.valid)
   `ILS_ASSERT_NEXT(a_shift_ends_in_rsp, clock, reset, cmd.shift && stat.shift_last, rsp_chan.valid)
   `ILS_ASSERT_SAME(a_flags_exclusive, clock, reset, rsp_chan.valid, !(rsp_chan.out_of_bounds && rsp_chan.full_res))

endmodule

[verif/indexed_list_store_core_tb.sv]
// Testbench for indexed_list_store_core: a directed table, then random requests.
// Responses are checked against the typed rows of the table or a shadow list kept in the testbench.
// Depends on ils_pkg, the ils_req_if and ils_rsp_if interfaces, and the core.
module tb;

   localparam int CAPACITY     = 256;
   localparam int RANDOM_ITEMS = 1120;
   localparam int PAUSE_AT     = 700;
   localparam int LIMIT_TIME   = 60_000_000;

   localparam ils_pkg::op_type OP_UNUSED_5 = 3'd5;
   localparam ils_pkg::op_type OP_UNUSED_6 = 3'd6;
   localparam ils_pkg::op_type OP_UNUSED_7 = 3'd7;

   typedef struct packed {
      ils_pkg::elem_type  read_data;
      logic               out_of_bounds;
      logic               full_res;
      ils_pkg::count_type count;
   } list_result_type;

   typedef struct {
      ils_pkg::op_type    op;
      ils_pkg::index_type index;
      ils_pkg::elem_type  element;
      int                 reps;
      bit                 typed;
      list_result_type    want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   ils_req_if req_chan ();
   ils_rsp_if rsp_chan ();

   ils_pkg::elem_type  shadow_words [CAPACITY];
   ils_pkg::count_type shadow_count;
   list_result_type    pending_results [$];
   stim_row_type       directed_rows [$];
   int                 mismatch_count = 0;
   int                 rsp_stall;
   bit                 calm;

   indexed_list_store_core #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (32)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   // Applies one request to the shadow list and returns the response it should give.
   function automatic list_result_type predict_list_result(input ils_pkg::op_type op,
                                                           input ils_pkg::index_type idx,
                                                           input ils_pkg::elem_type word);
      list_result_type res;
      bit              in_range;
      res      = '0;
      in_range = ils_pkg::count_type'(idx) < shadow_count;
      case (op)
         ils_pkg::OP_READ: begin
            if (in_range) res.read_data = shadow_words[idx];
            else res.out_of_bounds = 1'b1;
         end
         ils_pkg::OP_WRITE: begin
            if (in_range) shadow_words[idx] = word;
            else res.out_of_bounds = 1'b1;
         end
         ils_pkg::OP_APPEND: begin
            if (shadow_count >= ils_pkg::count_type'(CAPACITY)) begin
               res.full_res = 1'b1;
            end else begin
               shadow_words[ils_pkg::index_type'(shadow_count)] = word;
               shadow_count++;
            end
         end
         ils_pkg::OP_REMOVE: begin
            if (in_range) begin
               for (int k = idx; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k + 1];
               shadow_count--;
            end else begin
               res.out_of_bounds = 1'b1;
            end
         end
         ils_pkg::OP_CLEAR: shadow_count = '0;
         default: ;
      endcase
      res.count = shadow_count;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Holds valid high until the word is taken, then predicts its response.
   task automatic send_request(input ils_pkg::op_type op, input ils_pkg::index_type idx,
                               input ils_pkg::elem_type word, output list_result_type predicted);
      req_chan.valid   <= 1'b1;
      req_chan.op      <= op;
      req_chan.index   <= idx;
      req_chan.element <= word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = predict_list_result(op, idx, word);
   endtask

   task automatic idle_sender(input int gap, input bit drain);
      if (gap > 0 || drain) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
         while (drain && pending_results.size() != 0) @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 0;
         rsp_chan.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall      <= rsp_stall - 1;
         rsp_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 25) begin
         rsp_stall      <= pick_gap();
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : response_check
      list_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_results.size() == 0) begin
            $error("response word with no request waiting for it");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_chan.read_data !== want.read_data) begin
               $error("read_data: expected %h, got %h", want.read_data, rsp_chan.read_data);
               mismatch_count++;
            end
            if (rsp_chan.out_of_bounds !== want.out_of_bounds) begin
               $error("out_of_bounds: expected %b, got %b", want.out_of_bounds,
                      rsp_chan.out_of_bounds);
               mismatch_count++;
            end
            if (rsp_chan.full_res !== want.full_res) begin
               $error("full_res: expected %b, got %b", want.full_res, rsp_chan.full_res);
               mismatch_count++;
            end
            if (rsp_chan.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_chan.count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #LIMIT_TIME;
      $display("** indexed_list_store_core: FAILED **");
      $finish;
   end

   initial begin
      stim_row_type       row;
      list_result_type    predicted;
      ils_pkg::op_type    op;
      ils_pkg::index_type idx;
      ils_pkg::elem_type  word;
      int                 pick;
      int                 fill_left;
      bit                 stray;

      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.op      = ils_pkg::OP_READ;
      req_chan.index   = '0;
      req_chan.element = '0;
      calm             = 1'b0;
      shadow_count     = '0;
      fill_left        = 0;
      foreach (shadow_words[i]) shadow_words[i] = '0;

      // Rows with typed = 1 carry their response; the rest use the shadow list.
      directed_rows = '{
         '{ils_pkg::OP_READ,   8'd0,   32'h0,        1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd0}},
         '{ils_pkg::OP_WRITE,  8'd0,   32'hDEADBEEF, 1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd0}},
         '{ils_pkg::OP_REMOVE, 8'd255, 32'h0,        1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd0}},
         '{ils_pkg::OP_APPEND, 8'd0,   32'hFFFFFFFF, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd1}},
         '{ils_pkg::OP_APPEND, 8'd255, 32'h0,        1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_READ,   8'd0,   32'h0,        1,   1'b1, '{32'hFFFFFFFF, 1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_READ,   8'd1,   32'hFFFFFFFF, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_READ,   8'd2,   32'h0,        1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd2}},
         '{ils_pkg::OP_WRITE,  8'd1,   32'hA5A5A5A5, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_APPEND, 8'd0,   32'h12345678, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd3}},
         '{ils_pkg::OP_REMOVE, 8'd0,   32'h0,        1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_READ,   8'd0,   32'h0,        1,   1'b1, '{32'hA5A5A5A5, 1'b0, 1'b0, 9'd2}},
         '{OP_UNUSED_5,        8'd0,   32'hFFFFFFFF, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{OP_UNUSED_6,        8'd1,   32'h0,        1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{OP_UNUSED_7,        8'd255, 32'h5A5A5A5A, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd2}},
         '{ils_pkg::OP_CLEAR,  8'd0,   32'h0,        1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd0}},
         '{ils_pkg::OP_READ,   8'd0,   32'h0,        1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd0}},
         '{ils_pkg::OP_APPEND, 8'd0,   32'hC0DE0000, 256, 1'b0, '{32'h0,        1'b0, 1'b0, 9'd0}},
         '{ils_pkg::OP_APPEND, 8'd0,   32'hFFFFFFFF, 1,   1'b1, '{32'h0,        1'b0, 1'b1, 9'd256}},
         '{ils_pkg::OP_READ,   8'd255, 32'h0,        1,   1'b0, '{32'h0,        1'b0, 1'b0, 9'd0}},
         '{ils_pkg::OP_WRITE,  8'd255, 32'hFFFFFFFF, 1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd256}},
         '{ils_pkg::OP_REMOVE, 8'd0,   32'h0,        1,   1'b0, '{32'h0,        1'b0, 1'b0, 9'd0}},
         '{ils_pkg::OP_REMOVE, 8'd254, 32'h0,        1,   1'b0, '{32'h0,        1'b0, 1'b0, 9'd0}},
         '{ils_pkg::OP_READ,   8'd255, 32'h0,        1,   1'b1, '{32'h0,        1'b1, 1'b0, 9'd254}},
         '{ils_pkg::OP_CLEAR,  8'd0,   32'h0,        1,   1'b1, '{32'h0,        1'b0, 1'b0, 9'd0}}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         for (int r = 0; r < row.reps; r++) begin
            send_request(row.op, row.index, row.element + ils_pkg::elem_type'(r), predicted);
            pending_results.push_back(row.typed ? row.want : predicted);
            idle_sender(pick_gap(), 1'b0);
         end
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         calm  = (n >= 400 && n < 600);
         word  = $urandom;
         idx   = ils_pkg::index_type'($urandom);
         stray = 1'b0;
         // Append runs are what get the list up to capacity.
         if (n == 100) fill_left = 300;
         else if (fill_left == 0 && $urandom_range(0, 249) == 0)
            fill_left = $urandom_range(32, 300);
         if (fill_left > 0) begin
            op = ils_pkg::OP_APPEND;
            fill_left--;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 28) op = ils_pkg::OP_READ;
            else if (pick < 46) op = ils_pkg::OP_WRITE;
            else if (pick < 70) op = ils_pkg::OP_APPEND;
            else if (pick < 86) op = ils_pkg::OP_REMOVE;
            else if (pick < 89) op = ils_pkg::OP_CLEAR;
            else if (pick < 93) op = ils_pkg::op_type'($urandom_range(OP_UNUSED_5, OP_UNUSED_7));
            else begin
               stray = 1'b1;
               case ($urandom_range(0, 2))
                  0: op = ils_pkg::OP_READ;
                  1: op = ils_pkg::OP_WRITE;
                  default: op = ils_pkg::OP_REMOVE;
               endcase
            end
            if (op == ils_pkg::OP_READ || op == ils_pkg::OP_WRITE || op == ils_pkg::OP_REMOVE) begin
               if (!stray && shadow_count != 0)
                  idx = ils_pkg::index_type'($urandom_range(0, shadow_count - 1));
               else if (stray && shadow_count <= 255)
                  idx = ils_pkg::index_type'($urandom_range(shadow_count, 255));
            end
         end
         send_request(op, idx, word, predicted);
         pending_results.push_back(predicted);
         idle_sender(calm ? 0 : pick_gap(), n == PAUSE_AT || $urandom_range(0, 199) == 0);
      end

      idle_sender(0, 1'b1);
      calm = 1'b1;
      repeat (300) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("** indexed_list_store_core: PASSED **");
      else
         $display("** indexed_list_store_core: FAILED **");
      $finish;
   end

endmodule
